/* rtl/core/vht_pkg.sv */
// Shared types, constants and the arctangent step table of the heading block.
package vht_pkg;

    // Field and datapath widths
    localparam int STATUS_W     = 8;
    localparam int FIELD_W      = 16;
    localparam int HEADING_W    = 12;
    localparam int INPUT_SCALE  = 30;
    // Magnitude after negation and CORDIC gain stays below 2^47; keep a guard bit
    localparam int DW           = 49;
    // Integer bits of the angle accumulator (range -999 .. 2799 tenths)
    localparam int ANGLE_INT_W  = 13;
    localparam int WRAP_W       = 14;

    // Angle constants in tenths of a degree
    localparam int FULL_CIRCLE  = 3600;
    localparam int HALF_CIRCLE  = 180 * 10;
    localparam int QUARTER      = 900;
    localparam int THREE_QUARTER = 2700;
    localparam int HEADING_MAX  = FULL_CIRCLE - 1;

    // Status register: data ready flag
    localparam int DRDY_BIT     = 0;

    // Step table: atan(2^-i) in tenths of a degree, 24 fraction bits
    localparam int TABLE_FRAC   = 24;
    localparam int TABLE_LEN    = 24;
    localparam longint ATAN_TAB [0:TABLE_LEN-1] = '{
        64'sd7549747200, 64'sd4456876016, 64'sd2354890885, 64'sd1195379383,
        64'sd600009343,  64'sd300297169,  64'sd150185227,  64'sd75097196,
        64'sd37549171,   64'sd18774657,   64'sd9387338,    64'sd4693670,
        64'sd2346835,    64'sd1173418,    64'sd586709,     64'sd293354,
        64'sd146677,     64'sd73339,      64'sd36669,      64'sd18335,
        64'sd9167,       64'sd4584,       64'sd2292,       64'sd1146
    };

    // Control word that travels beside the CORDIC operands
    typedef struct packed {
        logic                 valid_res;
        logic                 special;
        logic [HEADING_W-1:0] fixed_heading;
    } vht_ctrl_t;

    // Round one step angle half up to the requested fraction bits
    function automatic longint atan_step(input int idx, input int frac);
        int     sh;
        longint half;
        sh   = TABLE_FRAC - frac;
        half = (sh > 0) ? (longint'(1) << (sh - 1)) : longint'(0);
        return (ATAN_TAB[idx] + half) >>> sh;
    endfunction

endpackage

/* rtl/core/vht_if.sv */
// Valid/ready channels for the sample input and the heading result.
interface vht_sample_if;
    logic                                valid;
    logic                                ready;
    logic [vht_pkg::STATUS_W-1:0]        status_byte;
    logic signed [vht_pkg::FIELD_W-1:0]  field_x;
    logic signed [vht_pkg::FIELD_W-1:0]  field_y;

    modport source (output valid, output status_byte, output field_x, output field_y,
                    input ready);
    modport sink   (input valid, input status_byte, input field_x, input field_y,
                    output ready);
endinterface

interface vht_result_if;
    logic                          valid;
    logic                          ready;
    logic [vht_pkg::HEADING_W-1:0] heading;
    logic                          valid_res;

    modport source (output valid, output heading, output valid_res, input ready);
    modport sink   (input valid, input heading, input valid_res, output ready);
endinterface

/* rtl/core/vht_stage.sv */
// One registered CORDIC vectoring micro-rotation with its control word.
module vht_stage #(
    parameter int SHIFT = 0,
    parameter int ZW    = 29,
    parameter logic signed [ZW-1:0] ANGLE = '0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic                           prev_valid,
    input  logic signed [vht_pkg::DW-1:0]  prev_x,
    input  logic signed [vht_pkg::DW-1:0]  prev_y,
    input  logic signed [ZW-1:0]           prev_z,
    input  vht_pkg::vht_ctrl_t             prev_ctrl,
    output logic                           cur_valid,
    output logic signed [vht_pkg::DW-1:0]  cur_x,
    output logic signed [vht_pkg::DW-1:0]  cur_y,
    output logic signed [ZW-1:0]           cur_z,
    output vht_pkg::vht_ctrl_t             cur_ctrl
);

    logic                          valid_reg;
    logic signed [vht_pkg::DW-1:0] x_reg, x_next;
    logic signed [vht_pkg::DW-1:0] y_reg, y_next;
    logic signed [ZW-1:0]          z_reg, z_next;
    vht_pkg::vht_ctrl_t            ctrl_reg;
    logic signed [vht_pkg::DW-1:0] x_sh;
    logic signed [vht_pkg::DW-1:0] y_sh;

    // Rotate toward the x axis: direction from the sign of y
    always_comb
    begin
        x_sh = prev_x >>> SHIFT;
        y_sh = prev_y >>> SHIFT;
        if (prev_y > 0)
        begin
            x_next = prev_x + y_sh;
            y_next = prev_y - x_sh;
            z_next = prev_z + ANGLE;
        end
        else
        begin
            x_next = prev_x - y_sh;
            y_next = prev_y + x_sh;
            z_next = prev_z - ANGLE;
        end
    end

    // Advance the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= prev_valid;
    end

    // Hold or load the payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            ctrl_reg <= prev_ctrl;
        end
    end

    assign cur_valid = valid_reg;
    assign cur_x     = x_reg;
    assign cur_y     = y_reg;
    assign cur_z     = z_reg;
    assign cur_ctrl  = ctrl_reg;

endmodule

/* rtl/core/vector_heading_tenths_top.sv */
// Top level of the compass heading pipeline: decode, CORDIC stages, output register.
//
// Usage:
//   sample carries a status byte and signed 16-bit X and Y field samples.
//   result carries the heading (0..3599 tenths of a degree, floor of
//   atan2(y, x)) and valid_res, a copy of status bit 0. Without data ready
//   the heading reads 0. Every sample gives exactly one result, in order.
//   Registers: one decode register, one register per micro-rotation and
//   one output register lie between sample transfer and result valid.
//   Throughput: one sample per cycle while the pipeline has room; each
//   micro-rotation has its own pipeline register, so nothing is shared
//   between items.
//   Stall: while result.ready is low the pipeline keeps filling its empty
//   stages; sample.ready drops only once every stage holds an item. A held
//   result keeps its payload until the transfer.
//   Reset: rst_n clears all stage valid bits at once; the pipeline is empty
//   and ready right after reset.
module vector_heading_tenths_top #(
    parameter int CORDIC_STEPS        = 16,
    parameter int ANGLE_FRACTION_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    vht_sample_if.sink    sample,
    vht_result_if.source  result
);

    localparam int S  = CORDIC_STEPS;
    localparam int F  = ANGLE_FRACTION_BITS;
    localparam int ZW = F + vht_pkg::ANGLE_INT_W;
    localparam int DW = vht_pkg::DW;
    localparam logic signed [ZW-1:0] Z_HALF =
        ZW'(longint'(vht_pkg::HALF_CIRCLE) << F);

    // Per-stage valid, payload and advance signals; index 0 is the decode register
    logic                 v_pipe   [0:S];
    logic signed [DW-1:0] x_pipe   [0:S];
    logic signed [DW-1:0] y_pipe   [0:S];
    logic signed [ZW-1:0] z_pipe   [0:S];
    vht_pkg::vht_ctrl_t   ctrl_pipe[0:S];
    logic                 adv      [0:S+1];

    // Decode stage
    logic                                pre_valid_reg;
    logic signed [DW-1:0]                pre_x_reg, pre_x_next;
    logic signed [DW-1:0]                pre_y_reg, pre_y_next;
    logic signed [ZW-1:0]                pre_z_reg, pre_z_next;
    vht_pkg::vht_ctrl_t                  pre_ctrl_reg, pre_ctrl_next;
    logic signed [vht_pkg::FIELD_W:0]    x_ext, y_ext;
    logic signed [vht_pkg::FIELD_W:0]    x_fold, y_fold;
    logic                                x_neg;

    // Output stage
    logic                                out_valid_reg;
    logic [vht_pkg::HEADING_W-1:0]       out_heading_reg, out_heading_next;
    logic                                out_vres_reg;
    logic signed [vht_pkg::ANGLE_INT_W-1:0] z_int;
    logic signed [vht_pkg::WRAP_W-1:0]   z_wrap;
    logic [vht_pkg::HEADING_W-1:0]       h_clamp;

    // Advance a stage when it is empty or the next one advances
    assign adv[S+1] = !out_valid_reg || result.ready;
    for (genvar k = 0; k <= S; k++)
    begin : g_adv
        assign adv[k] = !v_pipe[k] || adv[k+1];
    end
    assign sample.ready = adv[0];

    // Decode: axis and not-ready cases, fold left half plane, scale up
    always_comb
    begin
        x_ext  = {sample.field_x[vht_pkg::FIELD_W-1], sample.field_x};
        y_ext  = {sample.field_y[vht_pkg::FIELD_W-1], sample.field_y};
        x_neg  = sample.field_x < 0;
        x_fold = x_neg ? -x_ext : x_ext;
        y_fold = x_neg ? -y_ext : y_ext;
        pre_x_next = DW'(x_fold) <<< vht_pkg::INPUT_SCALE;
        pre_y_next = DW'(y_fold) <<< vht_pkg::INPUT_SCALE;
        pre_z_next = x_neg ? Z_HALF : '0;

        pre_ctrl_next.valid_res     = sample.status_byte[vht_pkg::DRDY_BIT];
        pre_ctrl_next.special       = 1'b1;
        pre_ctrl_next.fixed_heading = '0;
        if (!sample.status_byte[vht_pkg::DRDY_BIT])
            pre_ctrl_next.fixed_heading = '0;
        else if (sample.field_y == 0)
            pre_ctrl_next.fixed_heading = x_neg ?
                vht_pkg::HEADING_W'(vht_pkg::HALF_CIRCLE) : '0;
        else if (sample.field_x == 0)
            pre_ctrl_next.fixed_heading = (sample.field_y > 0) ?
                vht_pkg::HEADING_W'(vht_pkg::QUARTER) :
                vht_pkg::HEADING_W'(vht_pkg::THREE_QUARTER);
        else
            pre_ctrl_next.special = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_valid_reg <= 1'b0;
        else if (adv[0])
            pre_valid_reg <= sample.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            pre_x_reg    <= pre_x_next;
            pre_y_reg    <= pre_y_next;
            pre_z_reg    <= pre_z_next;
            pre_ctrl_reg <= pre_ctrl_next;
        end
    end

    assign v_pipe[0]    = pre_valid_reg;
    assign x_pipe[0]    = pre_x_reg;
    assign y_pipe[0]    = pre_y_reg;
    assign z_pipe[0]    = pre_z_reg;
    assign ctrl_pipe[0] = pre_ctrl_reg;

    // CORDIC micro-rotations, one register stage each
    for (genvar k = 0; k < S; k++)
    begin : g_rot
        vht_stage #(
            .SHIFT (k),
            .ZW    (ZW),
            .ANGLE (ZW'(vht_pkg::atan_step(k, F)))
        ) u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (adv[k+1]),
            .prev_valid (v_pipe[k]),
            .prev_x     (x_pipe[k]),
            .prev_y     (y_pipe[k]),
            .prev_z     (z_pipe[k]),
            .prev_ctrl  (ctrl_pipe[k]),
            .cur_valid  (v_pipe[k+1]),
            .cur_x      (x_pipe[k+1]),
            .cur_y      (y_pipe[k+1]),
            .cur_z      (z_pipe[k+1]),
            .cur_ctrl   (ctrl_pipe[k+1])
        );
    end

    // Floor to whole tenths, wrap negatives, clamp to the circle
    always_comb
    begin
        z_int  = z_pipe[S][ZW-1:F];
        z_wrap = {z_int[vht_pkg::ANGLE_INT_W-1], z_int};
        if (z_wrap < 0)
            z_wrap = z_wrap + vht_pkg::WRAP_W'(vht_pkg::FULL_CIRCLE);
        if (z_wrap < 0)
            h_clamp = '0;
        else if (z_wrap > vht_pkg::WRAP_W'(vht_pkg::HEADING_MAX))
            h_clamp = vht_pkg::HEADING_W'(vht_pkg::HEADING_MAX);
        else
            h_clamp = z_wrap[vht_pkg::HEADING_W-1:0];
        out_heading_next = ctrl_pipe[S].special ? ctrl_pipe[S].fixed_heading : h_clamp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv[S+1])
            out_valid_reg <= v_pipe[S];
    end

    always_ff @(posedge clk)
    begin
        if (adv[S+1])
        begin
            out_heading_reg <= out_heading_next;
            out_vres_reg    <= ctrl_pipe[S].valid_res;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.heading   = out_heading_reg;
    assign result.valid_res = out_vres_reg;

    // Input back-pressure only when every stage is full and the output stalls
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> (result.valid && !result.ready && pre_valid_reg))
        else $error("sample.ready low with room in the pipeline");

    // A sample transfer lands in the decode register
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> pre_valid_reg)
        else $error("sample transfer lost at the decode stage");

    // Results without data ready carry a zero heading
    a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.valid_res) |-> (result.heading == '0))
        else $error("nonzero heading without data ready");

    // Heading stays on the circle
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.heading <= vht_pkg::HEADING_W'(vht_pkg::HEADING_MAX)))
        else $error("heading above 3599");

endmodule

/* tb/vht_heading_checker.sv */
`timescale 1ns / 100ps
// Heading checker: watches both channels, predicts each heading and compares in order.
module vht_heading_checker #(
    parameter int CORDIC_STEPS        = 16,
    parameter int ANGLE_FRACTION_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    vht_sample_if        sample,
    vht_result_if        result,
    output int           fail_count,
    output int           pending
);

    // Clamp the rotation count to the step table length and the angle precision to its fraction bits
    localparam int STEPS_USED = (CORDIC_STEPS < 0) ? 0 :
                                (CORDIC_STEPS > vht_pkg::TABLE_LEN) ? vht_pkg::TABLE_LEN :
                                CORDIC_STEPS;
    localparam int FRAC_USED  = (ANGLE_FRACTION_BITS < 0) ? 0 :
                                (ANGLE_FRACTION_BITS > vht_pkg::TABLE_FRAC) ?
                                vht_pkg::TABLE_FRAC : ANGLE_FRACTION_BITS;

    typedef struct {
        logic [vht_pkg::HEADING_W-1:0] heading;
        logic                          valid_res;
    } heading_result_t;

    heading_result_t heading_queue[$];

    // Floor of atan2(fy, fx) in tenths, by fixed-point CORDIC vectoring
    function automatic logic [vht_pkg::HEADING_W-1:0] predict_heading(
        input logic signed [vht_pkg::FIELD_W-1:0] fx,
        input logic signed [vht_pkg::FIELD_W-1:0] fy
    );
        longint x;
        longint y;
        longint z;
        longint h;
        longint xs;
        longint ys;
        longint step;
        longint half;
        int     sh;
        x = fx;
        y = fy;
        // Axis vectors and the zero vector are exact
        if (y == 0)
            return (x < 0) ? vht_pkg::HEADING_W'(vht_pkg::HALF_CIRCLE) : '0;
        if (x == 0)
            return (y > 0) ? vht_pkg::HEADING_W'(vht_pkg::QUARTER) :
                             vht_pkg::HEADING_W'(vht_pkg::THREE_QUARTER);
        // Fold the left half plane onto the right one
        z = 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = longint'(vht_pkg::HALF_CIRCLE) <<< FRAC_USED;
        end
        x = x <<< vht_pkg::INPUT_SCALE;
        y = y <<< vht_pkg::INPUT_SCALE;
        sh   = vht_pkg::TABLE_FRAC - FRAC_USED;
        half = (sh > 0) ? (longint'(1) << (sh - 1)) : longint'(0);
        for (int i = 0; i < STEPS_USED; i++)
        begin
            xs   = x >>> i;
            ys   = y >>> i;
            step = (vht_pkg::ATAN_TAB[i] + half) >>> sh;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + step;
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - step;
            end
        end
        // Wrap negative angles, then clamp into the heading range
        h = z >>> FRAC_USED;
        if (h < 0)
            h = h + vht_pkg::FULL_CIRCLE;
        if (h < 0)
            h = 0;
        if (h > vht_pkg::HEADING_MAX)
            h = vht_pkg::HEADING_MAX;
        return vht_pkg::HEADING_W'(h);
    endfunction

    // Queue a prediction per sample transfer, check each result transfer
    always @(posedge clk or negedge rst_n)
    begin
        heading_result_t want;
        if (!rst_n)
        begin
            heading_queue.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (sample.valid && sample.ready)
            begin
                if (sample.status_byte[vht_pkg::DRDY_BIT])
                begin
                    want.heading   = predict_heading(sample.field_x, sample.field_y);
                    want.valid_res = 1'b1;
                end
                else
                begin
                    want.heading   = '0;
                    want.valid_res = 1'b0;
                end
                heading_queue.push_back(want);
            end
            if (result.valid && result.ready)
            begin
                if (heading_queue.size() == 0)
                begin
                    $error("result transfer with no heading pending: heading %0d valid_res %0d",
                           result.heading, result.valid_res);
                    fail_count++;
                end
                else
                begin
                    want = heading_queue.pop_front();
                    if (result.heading !== want.heading)
                    begin
                        $error("heading mismatch: expected %0d, actual %0d",
                               want.heading, result.heading);
                        fail_count++;
                    end
                    if (result.valid_res !== want.valid_res)
                    begin
                        $error("valid_res mismatch: expected %0d, actual %0d",
                               want.valid_res, result.valid_res);
                        fail_count++;
                    end
                end
            end
            pending = heading_queue.size();
        end
    end

endmodule

/* tb/tb_vector_heading_tenths_top.sv */
`timescale 1ns / 100ps
// Testbench top: clock, reset, sample stimulus, result backpressure and the verdict.
module tb_vector_heading_tenths_top;

    localparam int CORDIC_STEPS        = 16;
    localparam int ANGLE_FRACTION_BITS = 16;
    localparam int PIPE_LATENCY        = CORDIC_STEPS + 2;
    localparam int RANDOM_ITEMS        = 1440;
    localparam int STALL_LIMIT         = 3000;

    logic clk = 1'b0;
    logic rst_n;
    int   sender_idle_pct;
    int   receiver_stall_pct;
    int   fail_count;
    int   pending;
    int   quiet_cycles;

    vht_sample_if sample_ch ();
    vht_result_if result_ch ();

    vector_heading_tenths_top #(
        .CORDIC_STEPS        (CORDIC_STEPS),
        .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch)
    );

    vht_heading_checker #(
        .CORDIC_STEPS        (CORDIC_STEPS),
        .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample_ch),
        .result     (result_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    // Stall the result channel at random
    always @(negedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // End the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready)
            || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[vector_heading_tenths_top] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one sample, idling first at random, and hold it until the transfer
    task automatic send_sample(
        input logic [vht_pkg::STATUS_W-1:0]       status,
        input logic signed [vht_pkg::FIELD_W-1:0] fx,
        input logic signed [vht_pkg::FIELD_W-1:0] fy
    );
        while ($urandom_range(99) < sender_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.status_byte <= status;
        sample_ch.field_x     <= fx;
        sample_ch.field_y     <= fy;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Pick a field value: mostly full range, with zeros, extremes and small values
    function automatic logic signed [vht_pkg::FIELD_W-1:0] random_field();
        case ($urandom_range(9))
            0:       return '0;
            1:       return vht_pkg::FIELD_W'($signed($urandom_range(32)) - 16);
            2:
            begin
                case ($urandom_range(3))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return 16'sh0001;
                    default: return 16'shFFFF;
                endcase
            end
            default: return vht_pkg::FIELD_W'($urandom);
        endcase
    endfunction

    // Set data ready on most samples; the other status bits are random
    function automatic logic [vht_pkg::STATUS_W-1:0] random_status();
        logic [vht_pkg::STATUS_W-1:0] s;
        s                    = vht_pkg::STATUS_W'($urandom);
        s[vht_pkg::DRDY_BIT] = ($urandom_range(99) < 85);
        return s;
    endfunction

    initial
    begin
        int seg;
        // Drive all inputs to known values from time zero
        rst_n                 = 1'b0;
        sample_ch.valid       = 1'b0;
        sample_ch.status_byte = '0;
        sample_ch.field_x     = '0;
        sample_ch.field_y     = '0;
        sender_idle_pct       = 12;
        receiver_stall_pct    = 76;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: data not ready, zero vector, axes, quadrants, extremes
        send_sample(8'h00, 16'sd1000, 16'sd1000);
        send_sample(8'hFE, -16'sd500, 16'sd77);
        send_sample(8'h01, 16'sd0, 16'sd0);
        send_sample(8'hFF, 16'sd1234, 16'sd0);
        send_sample(8'h01, -16'sd1234, 16'sd0);
        send_sample(8'h01, 16'sd0, 16'sd4321);
        send_sample(8'h01, 16'sd0, -16'sd4321);
        send_sample(8'h01, 16'sd100, 16'sd100);
        send_sample(8'h01, -16'sd100, 16'sd100);
        send_sample(8'h01, -16'sd100, -16'sd100);
        send_sample(8'h01, 16'sd100, -16'sd100);
        send_sample(8'h01, 16'sh7FFF, 16'sh7FFF);
        send_sample(8'h01, 16'sh8000, 16'sh8000);
        send_sample(8'h01, 16'sh8000, 16'sh7FFF);
        send_sample(8'h01, 16'sh7FFF, 16'sh8000);
        send_sample(8'h01, 16'sh7FFF, -16'sd1);
        send_sample(8'h01, 16'sh7FFF, 16'sd1);
        send_sample(8'h01, 16'sh8000, -16'sd1);
        send_sample(8'h01, 16'sh8000, 16'sd1);
        send_sample(8'h01, 16'sd1, 16'sh7FFF);
        send_sample(8'h01, -16'sd1, 16'sh8000);
        send_sample(8'h55, 16'sh5555, 16'shAAAA);
        send_sample(8'hAA, 16'shAAAA, 16'sh5555);

        // Random samples over three idle patterns
        for (seg = 0; seg < 3; seg++)
        begin
            case (seg)
                0:
                begin
                    sender_idle_pct    = 12;
                    receiver_stall_pct = 76;
                end
                1:
                begin
                    sender_idle_pct    = 76;
                    receiver_stall_pct = 12;
                end
                default:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
            endcase
            repeat (RANDOM_ITEMS / 3)
                send_sample(random_status(), random_field(), random_field());
        end
        sample_ch.valid <= 1'b0;

        // Drain the pipeline, then give the verdict
        while (pending != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 4) @(negedge clk);
        if (fail_count == 0)
            $display("[vector_heading_tenths_top] OK");
        else
            $display("[vector_heading_tenths_top] ERROR");
        $finish;
    end

endmodule
